// ===== design/cab_pkg.sv =====
package cab_pkg;

    // field widths of one input word and one result word
    localparam int CHAN_W      = 8;
    localparam int READ_X_W    = 7;
    localparam int READ_Y_W    = 6;
    localparam int COLOR_W     = 3 * CHAN_W;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_DEST_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_KEEP  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MODE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SWAP_ORDER  = 3'd7;

    // source modes
    localparam logic [1:0] MODE_RGB      = 2'd0;
    localparam logic [1:0] MODE_RGB_PRES = 2'd1;
    localparam logic [1:0] MODE_MASK     = 2'd2;
    localparam logic [1:0] MODE_COVER    = 2'd3;

    // operations
    localparam logic OP_BLIT = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register and counter widths
    localparam int COORD_REG_W = 12;
    localparam int SIZE_W      = 12;
    localparam int CNT_W       = 11;
    localparam int ALPHA_W     = 9;
    localparam int MAX_SIZE    = 2048;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

    // default geometry
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_CLIP_X_FIRST  = 0;
    localparam int DEF_CLIP_X_LAST   = 127;
    localparam int DEF_CLIP_Y_FIRST  = 0;
    localparam int DEF_CLIP_Y_LAST   = 63;

    typedef struct packed {
        logic                operation;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic                present;
        logic [CHAN_W-1:0]   coverage;
        logic [READ_X_W-1:0] read_x;
        logic [READ_Y_W-1:0] read_y;
    } cab_in_t;

    typedef struct packed {
        logic                drawn;
        logic [READ_X_W-1:0] pixel_x;
        logic [READ_Y_W-1:0] pixel_y;
        logic [CHAN_W-1:0]   slot0;
        logic [CHAN_W-1:0]   slot1;
        logic [CHAN_W-1:0]   slot2;
        logic                blit_done;
    } cab_out_t;

endpackage

// ===== design/cab_in_if.sv =====
interface cab_in_if;
    import cab_pkg::*;

    logic    valid;
    logic    ready;
    cab_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/cab_out_if.sv =====
interface cab_out_if;
    import cab_pkg::*;

    logic     valid;
    logic     ready;
    cab_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/clipped_alpha_blit_top.sv =====
// channel    dir  handshake      word
// cfg_*      in   write enable   cfg_index selects register, cfg_data carries value
// pix_in     in   valid/ready    source pixel (operation 0) or frame read (operation 1)
// pix_out    out  valid/ready    one result word for every accepted word
//
// one word passes through the steps accept, frame store read, blend, write back and result;
// the next word is taken in the cycle after the result is loaded, not before the last is through.
// the frame store does that read-modify-write on its single read and single write port.
// after reset a clearing pass zeroes all SCREEN_WIDTH*SCREEN_HEIGHT frame store entries
// (8192 by default), one entry a cycle, with pix_in.ready low.
// a stalled pix_out holds its word; the block waits in the write-back step until it drains.
module clipped_alpha_blit_top #(
    parameter int SCREEN_WIDTH  = cab_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = cab_pkg::DEF_SCREEN_HEIGHT,
    parameter int CLIP_X_FIRST  = cab_pkg::DEF_CLIP_X_FIRST,
    parameter int CLIP_X_LAST   = cab_pkg::DEF_CLIP_X_LAST,
    parameter int CLIP_Y_FIRST  = cab_pkg::DEF_CLIP_Y_FIRST,
    parameter int CLIP_Y_LAST   = cab_pkg::DEF_CLIP_Y_LAST
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cab_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cab_pkg::CFG_DATA_W-1:0]     cfg_data,
    cab_in_if.sink                             pix_in,
    cab_out_if.source                          pix_out
);
    import cab_pkg::*;

    localparam int FRAME_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int XI_W        = $clog2(SCREEN_WIDTH);
    localparam int YI_W        = $clog2(SCREEN_HEIGHT);
    localparam int COORD_W     = COORD_REG_W + 1;
    localparam int X_MAX       = (CLIP_X_LAST < SCREEN_WIDTH - 1) ? CLIP_X_LAST
                                                                 : SCREEN_WIDTH - 1;
    localparam int Y_MAX       = (CLIP_Y_LAST < SCREEN_HEIGHT - 1) ? CLIP_Y_LAST
                                                                  : SCREEN_HEIGHT - 1;
    localparam logic signed [COORD_W-1:0] X_LO = COORD_W'(CLIP_X_FIRST);
    localparam logic signed [COORD_W-1:0] X_HI = COORD_W'(X_MAX);
    localparam logic signed [COORD_W-1:0] Y_LO = COORD_W'(CLIP_Y_FIRST);
    localparam logic signed [COORD_W-1:0] Y_HI = COORD_W'(Y_MAX);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(FRAME_DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    typedef logic [2:0][CHAN_W-1:0] chan3_t;

    // configuration registers
    logic signed [COORD_REG_W-1:0] dest_x_reg, dest_y_reg;
    logic [SIZE_W-1:0]             src_width_reg, src_height_reg;
    logic [ALPHA_W-1:0]            alpha_keep_reg;
    logic [1:0]                    source_mode_reg;
    logic [COLOR_W-1:0]            fill_color_reg;
    logic                          swap_order_reg;

    // control
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0]  col_reg, row_reg;
    logic              out_valid_reg;
    cab_out_t          out_data_reg;

    // per-word stage registers
    logic                      op_reg;
    logic                      draw_reg;
    logic                      done_reg;
    logic                      rd_ok_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [READ_X_W-1:0]       rx_reg;
    logic [READ_Y_W-1:0]       ry_reg;
    chan3_t                    raw_reg;
    logic [2:0][2*CHAN_W-1:0]  prod_reg;
    logic                      scale_reg;
    chan3_t                    new_reg;
    chan3_t                    blend_reg;
    logic [ADDR_W-1:0]         addr_reg;

    // combinational
    logic                      accept;
    logic                      cfg_size_zero_w, cfg_size_zero_h;
    logic [SIZE_W-1:0]         width_fix, height_fix;
    logic signed [COORD_W-1:0] x_now, y_now;
    logic                      in_win, use_now, done_now;
    logic [CNT_W-1:0]          col_next, row_next;
    logic [SIZE_W-1:0]         col_inc, row_inc;
    chan3_t                    raw_now, fill_ch, scaled, swapped, old_ch, blend_now;
    logic [2:0][2*CHAN_W-1:0]  prod_now;
    logic [2*CHAN_W-1:0]       div_sum [3];
    logic [2*CHAN_W:0]         mix_sum [3];
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [COLOR_W-1:0]        mem_wdata, mem_rdata;
    logic                      mem_we;
    logic                      out_free;
    logic [ALPHA_W-1:0]        alpha_inv;
    cab_out_t                  result_now;

    assign accept      = pix_in.valid && pix_in.ready;
    assign pix_in.ready = (state_reg == ST_IDLE);
    assign out_free    = !out_valid_reg || pix_out.ready;

    // size registers: zero acts as one, oversize clamps
    assign cfg_size_zero_w = (cfg_data[SIZE_W-1:0] == '0);
    assign cfg_size_zero_h = cfg_size_zero_w;
    always_comb
    begin
        width_fix = cfg_data[SIZE_W-1:0];
        if (cfg_size_zero_w)
        begin
            width_fix = SIZE_W'(1);
        end
        else if (cfg_data[SIZE_W-1:0] > SIZE_W'(MAX_SIZE))
        begin
            width_fix = SIZE_W'(MAX_SIZE);
        end
        height_fix = width_fix;
        if (cfg_size_zero_h)
        begin
            height_fix = SIZE_W'(1);
        end
    end

    // screen position and clip test
    always_comb
    begin
        x_now  = COORD_W'(dest_x_reg) + $signed({2'b00, col_reg});
        y_now  = COORD_W'(dest_y_reg) + $signed({2'b00, row_reg});
        in_win = (x_now >= X_LO) && (x_now <= X_HI) && (y_now >= Y_LO) && (y_now <= Y_HI);
    end

    // colour source and coverage products
    always_comb
    begin
        fill_ch = fill_color_reg;
        if (source_mode_reg == MODE_RGB || source_mode_reg == MODE_RGB_PRES)
        begin
            raw_now = {pix_in.data.red, pix_in.data.green, pix_in.data.blue};
            use_now = (source_mode_reg == MODE_RGB) || pix_in.data.present;
        end
        else
        begin
            raw_now = fill_ch;
            use_now = (pix_in.data.coverage != '0);
        end
        if (alpha_keep_reg[ALPHA_W-1])
        begin
            use_now = 1'b0;
        end
        for (int k = 0; k < 3; k++)
        begin
            prod_now[k] = fill_ch[k] * pix_in.data.coverage;
        end
    end

    // raster counters
    always_comb
    begin
        col_inc  = {1'b0, col_reg} + SIZE_W'(1);
        row_inc  = {1'b0, row_reg} + SIZE_W'(1);
        col_next = col_inc[CNT_W-1:0];
        row_next = row_reg;
        done_now = 1'b0;
        if (col_inc >= src_width_reg)
        begin
            col_next = '0;
            if (row_inc >= src_height_reg)
            begin
                row_next = '0;
                done_now = 1'b1;
            end
            else
            begin
                row_next = row_inc[CNT_W-1:0];
            end
        end
    end

    // divide by 255 for p below 65535, then channel order
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            div_sum[k] = prod_reg[k] + {{CHAN_W{1'b0}}, prod_reg[k][2*CHAN_W-1:CHAN_W]}
                         + (2*CHAN_W)'(1);
            scaled[k]  = scale_reg ? div_sum[k][2*CHAN_W-1:CHAN_W] : raw_reg[k];
        end
        swapped    = scaled;
        if (swap_order_reg)
        begin
            swapped[2] = scaled[0];
            swapped[0] = scaled[2];
        end
    end

    // frame store read address
    always_comb
    begin
        if (op_reg == OP_READ)
        begin
            rd_addr = ADDR_W'(ADDR_W'(ry_reg) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(rx_reg);
        end
        else
        begin
            rd_addr = ADDR_W'(ADDR_W'(y_reg[YI_W-1:0]) * ADDR_W'(SCREEN_WIDTH))
                      + ADDR_W'(x_reg[XI_W-1:0]);
        end
    end

    // blend: (old*a + new*(256-a)) >> 8
    always_comb
    begin
        old_ch    = mem_rdata;
        alpha_inv = ALPHA_W'(256) - alpha_keep_reg;
        for (int k = 0; k < 3; k++)
        begin
            mix_sum[k]   = (2*CHAN_W+1)'(old_ch[k] * alpha_keep_reg)
                           + (2*CHAN_W+1)'(new_reg[k] * alpha_inv);
            blend_now[k] = mix_sum[k][2*CHAN_W-1:CHAN_W];
        end
    end

    // frame store port control: clearing pass or write back
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = blend_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_OUT && out_free && draw_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // result word for the word in the write-back step
    always_comb
    begin
        result_now = '0;
        if (op_reg == OP_READ)
        begin
            result_now.pixel_x = rx_reg;
            result_now.pixel_y = ry_reg;
            if (rd_ok_reg)
            begin
                result_now.slot0 = blend_reg[2];
                result_now.slot1 = blend_reg[1];
                result_now.slot2 = blend_reg[0];
            end
        end
        else
        begin
            result_now.blit_done = done_reg;
            if (draw_reg)
            begin
                result_now.drawn   = 1'b1;
                result_now.pixel_x = x_reg[READ_X_W-1:0];
                result_now.pixel_y = y_reg[READ_Y_W-1:0];
                result_now.slot0   = blend_reg[2];
                result_now.slot1   = blend_reg[1];
                result_now.slot2   = blend_reg[0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_BLEND;
            ST_BLEND: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    cab_ram #(
        .DATA_W (COLOR_W),
        .DEPTH  (FRAME_DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            out_valid_reg   <= 1'b0;
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            src_width_reg   <= SIZE_W'(1);
            src_height_reg  <= SIZE_W'(1);
            alpha_keep_reg  <= '0;
            source_mode_reg <= MODE_RGB;
            fill_color_reg  <= '0;
            swap_order_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            // configuration write restarts the raster
            if (cfg_we)
            begin
                col_reg <= '0;
                row_reg <= '0;
                case (cfg_index)
                    REG_DEST_X:      dest_x_reg      <= cfg_data[COORD_REG_W-1:0];
                    REG_DEST_Y:      dest_y_reg      <= cfg_data[COORD_REG_W-1:0];
                    REG_SRC_WIDTH:   src_width_reg   <= width_fix;
                    REG_SRC_HEIGHT:  src_height_reg  <= height_fix;
                    REG_ALPHA_KEEP:  alpha_keep_reg  <= cfg_data[ALPHA_W-1:0];
                    REG_SOURCE_MODE: source_mode_reg <= cfg_data[1:0];
                    REG_FILL_COLOR:  fill_color_reg  <= cfg_data[COLOR_W-1:0];
                    REG_SWAP_ORDER:  swap_order_reg  <= cfg_data[0];
                    default:         swap_order_reg  <= swap_order_reg;
                endcase
            end
            else if (accept && pix_in.data.operation == OP_BLIT)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            // result word register
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= pix_in.data.operation;
            draw_reg  <= (pix_in.data.operation == OP_BLIT) && use_now && in_win;
            done_reg  <= (pix_in.data.operation == OP_BLIT) && done_now;
            x_reg     <= x_now;
            y_reg     <= y_now;
            rx_reg    <= pix_in.data.read_x;
            ry_reg    <= pix_in.data.read_y;
            rd_ok_reg <= (32'(pix_in.data.read_x) < SCREEN_WIDTH)
                         && (32'(pix_in.data.read_y) < SCREEN_HEIGHT);
            raw_reg   <= raw_now;
            prod_reg  <= prod_now;
            scale_reg <= (source_mode_reg == MODE_COVER)
                         && (pix_in.data.coverage != CHAN_FULL);
        end
        if (state_reg == ST_READ)
        begin
            new_reg  <= swapped;
            addr_reg <= rd_addr;
        end
        if (state_reg == ST_BLEND)
        begin
            blend_reg <= (op_reg == OP_READ) ? mem_rdata : blend_now;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg <= result_now;
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_data_reg;

`ifndef SYNTHESIS
    // the frame store is written only by the clearing pass or a write back
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || (state_reg == ST_OUT && draw_reg)))
        else $error("frame store written outside clear or write back");

    // no word is taken while the clearing pass runs
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !pix_in.ready)
        else $error("word accepted during clearing pass");

    // an accepted word always goes to the frame store read next
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ)
        else $error("accepted word did not start a frame store read");

    // a drawn result never comes from a read operation
    a_drawn_blit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free && op_reg == OP_READ) |=> !out_data_reg.drawn)
        else $error("read operation reported as drawn");
`endif

endmodule

// ===== design/cab_ram.sv =====
module cab_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sim/tb_clipped_alpha_blit_top.sv =====
`timescale 1ns / 100ps

module tb_clipped_alpha_blit_top;
    import cab_pkg::*;

    localparam int FRAME_WORDS  = DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT;
    localparam int RANDOM_WORDS = 1250;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_CAP   = 100;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cab_in_if  pix_in ();
    cab_out_if pix_out ();

    clipped_alpha_blit_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    // words waiting to be offered and result words still owed by the block
    cab_in_t  queued_pixels[$];
    cab_out_t owed_results[$];

    // shadow copy of the frame store, counters and registers
    logic [COLOR_W-1:0] frame_copy [0:FRAME_WORDS-1];
    int                 col_cnt;
    int                 row_cnt;
    int                 dx_copy;
    int                 dy_copy;
    int                 w_copy;
    int                 h_copy;
    int unsigned        alpha_copy;
    logic [1:0]         mode_copy;
    logic [COLOR_W-1:0] fill_copy;
    logic               swap_copy;

    int   failures;
    int   cycle_count;
    int   offer_gap_pct;
    int   accept_gap_pct;
    logic word_taken;
    logic hold_req;
    int   hold_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one channel blended as old*a + new*(256-a), scaled back by 256
    function automatic logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] prev,
                                                   logic [CHAN_W-1:0] fresh);
        int unsigned sum;
        sum = prev * alpha_copy + fresh * (256 - alpha_copy);
        return sum[CHAN_W+7:8];
    endfunction

    function automatic logic [CHAN_W-1:0] cover_scale(logic [CHAN_W-1:0] c,
                                                      logic [CHAN_W-1:0] cov);
        int unsigned prod;
        prod = (c * cov) / CHAN_FULL;
        return prod[CHAN_W-1:0];
    endfunction

    function automatic int fix_size(logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIZE)
            return MAX_SIZE;
        return int'(v);
    endfunction

    // expected result word for one accepted word, updating the shadow state
    function automatic cab_out_t blit_outcome(cab_in_t w);
        cab_out_t           r;
        logic [CHAN_W-1:0]  c0, c1, c2, s0, s2;
        logic [COLOR_W-1:0] prev;
        logic               hit;
        int                 x, y, idx;
        r = '0;
        if (w.operation == OP_READ)
        begin
            r.pixel_x = w.read_x;
            r.pixel_y = w.read_y;
            {r.slot0, r.slot1, r.slot2} = frame_copy[w.read_y * DEF_SCREEN_WIDTH + w.read_x];
        end
        else
        begin
            // color source
            if (mode_copy == MODE_RGB || mode_copy == MODE_RGB_PRES)
            begin
                c0 = w.red;
                c1 = w.green;
                c2 = w.blue;
                hit = (mode_copy == MODE_RGB) || w.present;
            end
            else
            begin
                {c0, c1, c2} = fill_copy;
                hit = (w.coverage != 0);
                if (mode_copy == MODE_COVER && w.coverage != 0 && w.coverage != CHAN_FULL)
                begin
                    c0 = cover_scale(c0, w.coverage);
                    c1 = cover_scale(c1, w.coverage);
                    c2 = cover_scale(c2, w.coverage);
                end
            end
            if (alpha_copy >= 256)
                hit = 1'b0;

            // placement, clip and blend
            x = dx_copy + col_cnt;
            y = dy_copy + row_cnt;
            if (hit && x >= DEF_CLIP_X_FIRST && x <= DEF_CLIP_X_LAST && x < DEF_SCREEN_WIDTH
                && y >= DEF_CLIP_Y_FIRST && y <= DEF_CLIP_Y_LAST && y < DEF_SCREEN_HEIGHT)
            begin
                idx  = y * DEF_SCREEN_WIDTH + x;
                prev = frame_copy[idx];
                s0 = swap_copy ? c2 : c0;
                s2 = swap_copy ? c0 : c2;
                r.slot0   = mix_chan(prev[23:16], s0);
                r.slot1   = mix_chan(prev[15:8], c1);
                r.slot2   = mix_chan(prev[7:0], s2);
                r.drawn   = 1'b1;
                r.pixel_x = x[READ_X_W-1:0];
                r.pixel_y = y[READ_Y_W-1:0];
                frame_copy[idx] = {r.slot0, r.slot1, r.slot2};
            end

            // raster counters
            if (col_cnt + 1 >= w_copy)
            begin
                col_cnt = 0;
                if (row_cnt + 1 >= h_copy)
                begin
                    row_cnt     = 0;
                    r.blit_done = 1'b1;
                end
                else
                    row_cnt = row_cnt + 1;
            end
            else
                col_cnt = col_cnt + 1;
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            failures++;
            if (failures <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
        end
    endtask

    // monitor: check result words, record accepted words
    always @(posedge clk)
    begin
        cab_out_t want;
        if (rst_n)
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_CAP)
                        $display("%0t: result word with none expected, expected none, actual %h",
                                 $time, pix_out.data);
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare_field("drawn", 32'(want.drawn), 32'(pix_out.data.drawn));
                    compare_field("pixel_x", 32'(want.pixel_x), 32'(pix_out.data.pixel_x));
                    compare_field("pixel_y", 32'(want.pixel_y), 32'(pix_out.data.pixel_y));
                    compare_field("slot0", 32'(want.slot0), 32'(pix_out.data.slot0));
                    compare_field("slot1", 32'(want.slot1), 32'(pix_out.data.slot1));
                    compare_field("slot2", 32'(want.slot2), 32'(pix_out.data.slot2));
                    compare_field("blit_done", 32'(want.blit_done),
                                  32'(pix_out.data.blit_done));
                end
            end
            if (pix_in.valid && pix_in.ready)
            begin
                owed_results.push_back(blit_outcome(pix_in.data));
                void'(queued_pixels.pop_front());
                word_taken = 1'b1;
            end
        end
    end

    // driver: offer queued words, hold a word until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pix_in.valid && !word_taken)
            begin
                // word still on offer
            end
            else if (queued_pixels.size() > 0 && $urandom_range(99) >= offer_gap_pct)
            begin
                pix_in.valid <= 1'b1;
                pix_in.data  <= queued_pixels[0];
            end
            else
                pix_in.valid <= 1'b0;
            word_taken = 1'b0;
        end
    end

    // receiver: random stalls plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            pix_out.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            pix_out.ready <= ($urandom_range(99) >= accept_gap_pct);
    end

    // register write, mirrored into the shadow registers
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_DEST_X:      dx_copy = int'($signed(val[COORD_REG_W-1:0]));
            REG_DEST_Y:      dy_copy = int'($signed(val[COORD_REG_W-1:0]));
            REG_SRC_WIDTH:   w_copy = fix_size(val[SIZE_W-1:0]);
            REG_SRC_HEIGHT:  h_copy = fix_size(val[SIZE_W-1:0]);
            REG_ALPHA_KEEP:  alpha_copy = 32'(val[ALPHA_W-1:0]);
            REG_SOURCE_MODE: mode_copy = val[1:0];
            REG_FILL_COLOR:  fill_copy = val[COLOR_W-1:0];
            REG_SWAP_ORDER:  swap_copy = val[0];
            default:         ;
        endcase
        col_cnt = 0;
        row_cnt = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random noise above a register's width
    function automatic logic [CFG_DATA_W-1:0] pad_high(logic [CFG_DATA_W-1:0] v, int wd);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] noise;
        keep  = ~({CFG_DATA_W{1'b1}} << wd);
        noise = CFG_DATA_W'($urandom);
        return (v & keep) | (noise & ~keep);
    endfunction

    task automatic set_blit(int dx, int dy, int w, int h, int alpha, int mode, int fill,
                            int swap);
        write_reg(REG_DEST_X, pad_high(CFG_DATA_W'(dx), COORD_REG_W));
        write_reg(REG_DEST_Y, pad_high(CFG_DATA_W'(dy), COORD_REG_W));
        write_reg(REG_SRC_WIDTH, pad_high(CFG_DATA_W'(w), SIZE_W));
        write_reg(REG_SRC_HEIGHT, pad_high(CFG_DATA_W'(h), SIZE_W));
        write_reg(REG_ALPHA_KEEP, pad_high(CFG_DATA_W'(alpha), ALPHA_W));
        write_reg(REG_SOURCE_MODE, pad_high(CFG_DATA_W'(mode), $bits(MODE_RGB)));
        write_reg(REG_FILL_COLOR, pad_high(CFG_DATA_W'(fill), COLOR_W));
        write_reg(REG_SWAP_ORDER, pad_high(CFG_DATA_W'(swap), 1));
    endtask

    function automatic cab_in_t noise_word();
        cab_in_t w;
        w.operation = OP_BLIT;
        w.red       = CHAN_W'($urandom);
        w.green     = CHAN_W'($urandom);
        w.blue      = CHAN_W'($urandom);
        w.present   = 1'($urandom);
        w.coverage  = CHAN_W'($urandom);
        w.read_x    = READ_X_W'($urandom);
        w.read_y    = READ_Y_W'($urandom);
        return w;
    endfunction

    task automatic push_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b, logic pres, logic [CHAN_W-1:0] cov);
        cab_in_t w;
        w          = noise_word();
        w.red      = r;
        w.green    = g;
        w.blue     = b;
        w.present  = pres;
        w.coverage = cov;
        queued_pixels.push_back(w);
    endtask

    task automatic push_read(logic [READ_X_W-1:0] x, logic [READ_Y_W-1:0] y);
        cab_in_t w;
        w           = noise_word();
        w.operation = OP_READ;
        w.read_x    = x;
        w.read_y    = y;
        queued_pixels.push_back(w);
    endtask

    function automatic logic [CHAN_W-1:0] pick_chan();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return CHAN_FULL;
        return CHAN_W'($urandom);
    endfunction

    // wait until every queued word is taken and every result has come back
    task automatic wait_idle();
        while (queued_pixels.size() != 0 || owed_results.size() != 0 || pix_in.valid)
            @(posedge clk);
    endtask

    // one random setting followed by a run of random words
    task automatic random_phase(int n, int phase);
        int r, dx, dy, w, h, alpha, fill, i;
        r = $urandom_range(99);
        if (r < 60)
            dx = $urandom_range(138) - 8;
        else if (r < 70)
            dx = -2048;
        else if (r < 80)
            dx = 2047;
        else
            dx = $urandom_range(4095);
        r = $urandom_range(99);
        if (r < 60)
            dy = $urandom_range(74) - 8;
        else if (r < 70)
            dy = -2048;
        else if (r < 80)
            dy = 2047;
        else
            dy = $urandom_range(4095);
        r = $urandom_range(99);
        if (r < 75)
            w = $urandom_range(8, 1);
        else if (r < 90)
            w = $urandom_range(40, 1);
        else if (r < 95)
            w = MAX_SIZE;
        else
            w = $urandom_range(4095);
        r = $urandom_range(99);
        if (r < 75)
            h = $urandom_range(6, 1);
        else if (r < 90)
            h = $urandom_range(20, 1);
        else if (r < 95)
            h = MAX_SIZE;
        else
            h = $urandom_range(4095);
        r = $urandom_range(99);
        if (r < 30)
            alpha = 0;
        else if (r < 40)
            alpha = 256;
        else if (r < 50)
            alpha = 255;
        else if (r < 55)
            alpha = 1;
        else if (r < 90)
            alpha = $urandom_range(256);
        else
            alpha = $urandom_range(511);
        r = $urandom_range(99);
        if (r < 10)
            fill = 24'hFFFFFF;
        else if (r < 15)
            fill = 0;
        else
            fill = $urandom_range(24'hFFFFFF);
        set_blit(dx, dy, w, h, alpha, $urandom_range(3), fill, $urandom_range(1));

        for (i = 0; i < n; i++)
        begin
            // sender pause in the middle of one run
            if (phase == 2 && i == n / 2)
                wait_idle();
            if ($urandom_range(99) < 15)
            begin
                if ($urandom_range(1))
                    push_read(READ_X_W'(dx + $urandom_range(7)),
                              READ_Y_W'(dy + $urandom_range(7)));
                else
                    push_read(READ_X_W'($urandom), READ_Y_W'($urandom));
            end
            else
                push_pixel(pick_chan(), pick_chan(), pick_chan(), 1'($urandom_range(1)),
                           pick_chan());
        end

        // long receiver hold while the sender keeps offering
        if (phase == 4)
        begin
            @(posedge clk);
            hold_req = 1'b1;
        end
        wait_idle();
    endtask

    initial
    begin
        int sent, n, phase;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pix_in.valid  = 1'b0;
        pix_in.data   = '0;
        pix_out.ready = 1'b0;
        failures      = 0;
        cycle_count   = 0;
        word_taken    = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        foreach (frame_copy[i])
            frame_copy[i] = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        dx_copy    = 0;
        dy_copy    = 0;
        w_copy     = 1;
        h_copy     = 1;
        alpha_copy = 0;
        mode_copy  = MODE_RGB;
        fill_copy  = '0;
        swap_copy  = 1'b0;
        offer_gap_pct  = 34;
        accept_gap_pct = 53;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // frame store clearing pass
        while (pix_in.ready !== 1'b1)
            @(posedge clk);

        // reset settings: read of a cleared entry, 1x1 blit at the origin, far corner read
        push_read(0, 0);
        push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00);
        push_read(7'h7F, 6'h3F);
        wait_idle();

        // bottom right corner, clipped on the right and below
        set_blit(126, 63, 3, 2, 0, int'(MODE_RGB), 0, 0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        push_pixel(8'hFF, 8'h00, 8'h00, 1'b1, 8'h01);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 8'h80);
        push_pixel(8'h00, 8'h00, 8'hFF, 1'b1, 8'hFE);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        wait_idle();

        // left edge clip, presence bit, half blend, swapped channels
        set_blit(-2, 0, 4, 1, 128, int'(MODE_RGB_PRES), 0, 1);
        push_pixel(8'd10, 8'd20, 8'd30, 1'b1, 8'h00);
        push_pixel(8'd200, 8'd100, 8'd50, 1'b0, 8'h00);
        push_pixel(8'hFF, 8'h80, 8'h00, 1'b1, 8'h00);
        push_pixel(8'd12, 8'd34, 8'd56, 1'b0, 8'h00);
        push_read(0, 0);
        wait_idle();

        // binary mask, zero coverage skips
        set_blit(10, 10, 2, 1, 0, int'(MODE_MASK), 24'hFF00A5, 0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0, 8'd77);
        wait_idle();

        // coverage mask: skip, smallest, middle, just below full, full
        set_blit(20, 20, 5, 1, 1, int'(MODE_COVER), 24'h80FF3C, 1);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h01);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h80);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFE);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        wait_idle();

        // full keep draws nothing, size zero and oversize
        set_blit(30, 30, 0, 4095, 256, int'(MODE_RGB), 0, 0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        wait_idle();

        // keep above full, extreme placement, largest sizes
        set_blit(2047, -2048, MAX_SIZE, MAX_SIZE, 511, int'(MODE_COVER), 24'hFFFFFF, 1);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        push_read(30, 30);
        wait_idle();

        // random settings and words, idling swapped after one third, then none for the last third
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent < RANDOM_WORDS / 3)
            begin
                offer_gap_pct  = 34;
                accept_gap_pct = 53;
            end
            else if (sent < 2 * RANDOM_WORDS / 3)
            begin
                offer_gap_pct  = 53;
                accept_gap_pct = 34;
            end
            else
            begin
                offer_gap_pct  = 0;
                accept_gap_pct = 0;
            end
            n = $urandom_range(60, 30);
            random_phase(n, phase);
            sent  = sent + n;
            phase = phase + 1;
        end

        // drain and allow for stray results
        wait_idle();
        repeat (20) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            failures++;
            $display("%0t: result words outstanding, expected 0, actual %0d",
                     $time, owed_results.size());
        end
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
